@@ src/cdu_pkg.sv @@
// ----------------------------------------------------------------------------
// cdu_pkg
// Types, calendar tables and constant-divide helpers for the calendar date
// unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cdu_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DOY_W   = 9;
    localparam int WEEK_W  = 6;
    localparam int DIFF_W  = 22;
    localparam int COUNT_W = 24;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // 2^17 / 25 rounded up; exact for inputs below 43690
    localparam logic [12:0] DIV25_MUL = 13'd5243;
    // 2^11 / 7 rounded up; exact for inputs below 380
    localparam logic [9:0]  DIV7_MUL  = 10'd293;

    localparam logic [COUNT_W-1:0] DIFF_MAX = 24'd4194303;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               leap;
    } cdu_date_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  next_year;
        logic [MONTH_W-1:0] next_month;
        logic [DAY_W-1:0]   next_day;
        logic [YEAR_W-1:0]  prev_year;
        logic [MONTH_W-1:0] prev_month;
        logic [DAY_W-1:0]   prev_day;
        logic [DOY_W-1:0]   day_of_year;
        logic [WEEK_W-1:0]  week_of_year;
    } cdu_nbr_t;

    typedef struct packed {
        cdu_nbr_t           nbr;
        logic               leap_flag;
        logic [DIFF_W-1:0]  days_between;
    } cdu_result_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            MONTH_FEB: begin
                n = leap ? 5'd29 : 5'd28;
            end
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
                n = 5'd30;
            end
            default: begin
                n = 5'd31;
            end
        endcase
        return n;
    endfunction

    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] s;
        case (m)
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd59;
            4'd4:    s = 9'd90;
            4'd5:    s = 9'd120;
            4'd6:    s = 9'd151;
            4'd7:    s = 9'd181;
            4'd8:    s = 9'd212;
            4'd9:    s = 9'd243;
            4'd10:   s = 9'd273;
            4'd11:   s = 9'd304;
            4'd12:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] div25(input logic [12:0] u);
        logic [25:0] p;
        p = u * DIV25_MUL;
        return p[24:17];
    endfunction

    function automatic logic [WEEK_W-1:0] ceil_div7(input logic [DOY_W-1:0] doy);
        logic [9:0]  x;
        logic [19:0] p;
        x = {1'b0, doy} + 10'd6;
        p = x * DIV7_MUL;
        return p[16:11];
    endfunction

endpackage

`default_nettype wire

@@ src/cdu_date_calc.sv @@
// ----------------------------------------------------------------------------
// cdu_date_calc
// Clamps one raw date to a valid month and day, flags a leap year and forms
// its absolute day count (March-based leap days, 400-year offset).
// ----------------------------------------------------------------------------
`default_nettype none

module cdu_date_calc
    import cdu_pkg::*;
(
    input  wire logic [YEAR_W-1:0]  year,
    input  wire logic [MONTH_W-1:0] month,
    input  wire logic [DAY_W-1:0]   day,
    output cdu_date_t               date,
    output logic [COUNT_W-1:0]      day_count
);

    logic [MONTH_W-1:0] month_c;
    logic [DAY_W-1:0]   day_c;
    logic [DAY_W-1:0]   mlen;
    logic [7:0]         yq;
    logic               div100;
    logic               leap;
    logic [14:0]        t;
    logic [12:0]        t4;
    logic [7:0]         t100;

    always_comb begin
        if (month == 4'd0) begin
            month_c = MONTH_JAN;
        end else if (month > MONTH_DEC) begin
            month_c = MONTH_DEC;
        end else begin
            month_c = month;
        end
    end

    // year / 100 for multiples of four
    assign yq     = div25({1'b0, year[YEAR_W-1:2]});
    assign div100 = (year[1:0] == 2'b00) && ((12'(yq) * 12'd25) == year[YEAR_W-1:2]);
    assign leap   = (year[1:0] == 2'b00) && (!div100 || (yq[1:0] == 2'b00));

    assign mlen = month_len(month_c, leap);

    always_comb begin
        if (day == 5'd0) begin
            day_c = 5'd1;
        end else if (day > mlen) begin
            day_c = mlen;
        end else begin
            day_c = day;
        end
    end

    assign t    = {1'b0, year} + 15'd400 - 15'((month_c <= MONTH_FEB) ? 1 : 0);
    assign t4   = t[14:2];
    assign t100 = div25(t4);

    assign day_count = COUNT_W'(year) * 24'd365
                     + COUNT_W'(month_start(month_c))
                     + COUNT_W'(day_c)
                     + COUNT_W'(t4)
                     - COUNT_W'(t100)
                     + COUNT_W'(t100[7:2]);

    assign date = {year, month_c, day_c, leap};

endmodule

`default_nettype wire

@@ src/cdu_neighbor.sv @@
// ----------------------------------------------------------------------------
// cdu_neighbor
// Next day, previous day, day of year and week of year of a clean date.
// ----------------------------------------------------------------------------
`default_nettype none

module cdu_neighbor
    import cdu_pkg::*;
(
    input  cdu_date_t date,
    output cdu_nbr_t  nbr
);

    logic [MONTH_W-1:0] pm;
    logic [DOY_W-1:0]   doy;

    assign pm = date.month - 4'd1;

    assign doy = month_start(date.month) + DOY_W'(date.day)
               + DOY_W'((date.month > MONTH_FEB) && date.leap);

    always_comb begin
        nbr.next_year  = date.year;
        nbr.next_month = date.month;
        nbr.next_day   = date.day + 5'd1;
        if (date.day == month_len(date.month, date.leap)) begin
            nbr.next_day = 5'd1;
            if (date.month == MONTH_DEC) begin
                nbr.next_year  = date.year + 14'd1;
                nbr.next_month = MONTH_JAN;
            end else begin
                nbr.next_month = date.month + 4'd1;
            end
        end

        nbr.prev_year  = date.year;
        nbr.prev_month = date.month;
        nbr.prev_day   = date.day - 5'd1;
        if (date.day == 5'd1) begin
            if (date.month == MONTH_JAN) begin
                nbr.prev_year  = date.year - 14'd1;
                nbr.prev_month = MONTH_DEC;
                nbr.prev_day   = 5'd31;
            end else begin
                nbr.prev_month = pm;
                nbr.prev_day   = month_len(pm, date.leap);
            end
        end

        nbr.day_of_year  = doy;
        nbr.week_of_year = ceil_div7(doy);
    end

endmodule

`default_nettype wire

@@ src/calendar_date_unit.sv @@
// ----------------------------------------------------------------------------
// calendar_date_unit
// Gregorian day arithmetic on two dates: neighbors, ordinal day and week of
// the first date, and distance in days between the two.
// ----------------------------------------------------------------------------
// Takes one pair of dates per cycle, unless m_ready holds the result back,
// and returns one result per pair. A transfer loads the input register;
// the result register loads from it when the output side is free, and
// m_valid rises with that load. All date arithmetic is a single pass of
// combinational logic between the two registers. While a result waits on
// m_ready, one more pair is taken only if the input register is empty.
// Months out of range are clamped to January or December and days to 1 or
// the month's last day before any use; days_between saturates at 4194303.
`default_nettype none

module calendar_date_unit
    import cdu_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [YEAR_W-1:0]  s_first_year,
    input  wire logic [MONTH_W-1:0] s_first_month,
    input  wire logic [DAY_W-1:0]   s_first_day,
    input  wire logic [YEAR_W-1:0]  s_second_year,
    input  wire logic [MONTH_W-1:0] s_second_month,
    input  wire logic [DAY_W-1:0]   s_second_day,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [YEAR_W-1:0]       m_next_year,
    output logic [MONTH_W-1:0]      m_next_month,
    output logic [DAY_W-1:0]        m_next_day,
    output logic [YEAR_W-1:0]       m_prev_year,
    output logic [MONTH_W-1:0]      m_prev_month,
    output logic [DAY_W-1:0]        m_prev_day,
    output logic                    m_leap_flag,
    output logic [DOY_W-1:0]        m_day_of_year,
    output logic [WEEK_W-1:0]       m_week_of_year,
    output logic [DIFF_W-1:0]       m_days_between
);

    logic               in_valid_reg, in_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic [YEAR_W-1:0]  y1_reg, y2_reg;
    logic [MONTH_W-1:0] m1_reg, m2_reg;
    logic [DAY_W-1:0]   d1_reg, d2_reg;
    cdu_result_t        res_reg, res_next;

    logic               out_ready;
    logic               in_xfer;
    logic               res_load;
    cdu_date_t          date_a, date_b;
    logic [COUNT_W-1:0] count_a, count_b;
    logic [COUNT_W-1:0] diff;
    cdu_nbr_t           nbr;

    assign out_ready = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_ready;
    assign in_xfer   = s_valid && s_ready;
    assign res_load  = in_valid_reg && out_ready;

    assign in_valid_next  = in_xfer || (in_valid_reg && !out_ready);
    assign out_valid_next = res_load || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            y1_reg <= s_first_year;
            m1_reg <= s_first_month;
            d1_reg <= s_first_day;
            y2_reg <= s_second_year;
            m2_reg <= s_second_month;
            d2_reg <= s_second_day;
        end
        if (res_load) begin
            res_reg <= res_next;
        end
    end

    cdu_date_calc u_calc_a (
        .year      (y1_reg),
        .month     (m1_reg),
        .day       (d1_reg),
        .date      (date_a),
        .day_count (count_a)
    );

    cdu_date_calc u_calc_b (
        .year      (y2_reg),
        .month     (m2_reg),
        .day       (d2_reg),
        .date      (date_b),
        .day_count (count_b)
    );

    cdu_neighbor u_nbr (
        .date (date_a),
        .nbr  (nbr)
    );

    assign diff = (count_a > count_b) ? (count_a - count_b) : (count_b - count_a);

    always_comb begin
        res_next.nbr          = nbr;
        res_next.leap_flag    = date_a.leap;
        res_next.days_between = (diff > DIFF_MAX) ? DIFF_MAX[DIFF_W-1:0] : diff[DIFF_W-1:0];
    end

    assign m_valid        = out_valid_reg;
    assign m_next_year    = res_reg.nbr.next_year;
    assign m_next_month   = res_reg.nbr.next_month;
    assign m_next_day     = res_reg.nbr.next_day;
    assign m_prev_year    = res_reg.nbr.prev_year;
    assign m_prev_month   = res_reg.nbr.prev_month;
    assign m_prev_day     = res_reg.nbr.prev_day;
    assign m_leap_flag    = res_reg.leap_flag;
    assign m_day_of_year  = res_reg.nbr.day_of_year;
    assign m_week_of_year = res_reg.nbr.week_of_year;
    assign m_days_between = res_reg.days_between;

`ifndef SYNTHESIS
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !in_valid_reg && !out_valid_reg)
        else $error("pipeline valid not cleared by reset");

    a_in_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("input transfer lost");

    a_in_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_ready |=> out_valid_reg)
        else $error("item did not reach result register");

    a_in_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_ready |=> in_valid_reg && $stable(y1_reg) && $stable(y2_reg))
        else $error("stalled input item dropped or changed");

    a_doy_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_day_of_year != 9'd0 && (m_leap_flag || m_day_of_year <= 9'd365))
        else $error("day of year out of range");
`endif

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the calendar date unit.
// ----------------------------------------------------------------------------
// A short table of dates is sent first: range limits, year wrap, leap days,
// clamped months and days, and saturated distance. Some rows carry typed
// answers and the rest are scored by the bench's own calendar arithmetic.
// After that comes a long run of random date pairs. Most are valid dates,
// biased toward month ends, century years and leap days. The rest are raw
// bit patterns. Both channels idle at random, and there are stall-free phases.
// ----------------------------------------------------------------------------

module tb
    import cdu_pkg::*;
();

    localparam int ITEMS      = 1100;
    localparam int PHASE_LEN  = 110;
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic [YEAR_W-1:0]  next_year;
        logic [MONTH_W-1:0] next_month;
        logic [DAY_W-1:0]   next_day;
        logic [YEAR_W-1:0]  prev_year;
        logic [MONTH_W-1:0] prev_month;
        logic [DAY_W-1:0]   prev_day;
        logic               leap_flag;
        logic [DOY_W-1:0]   day_of_year;
        logic [WEEK_W-1:0]  week_of_year;
        logic [DIFF_W-1:0]  days_between;
    } date_answer_t;

    typedef struct {
        logic [YEAR_W-1:0]  fy;
        logic [MONTH_W-1:0] fm;
        logic [DAY_W-1:0]   fd;
        logic [YEAR_W-1:0]  sy;
        logic [MONTH_W-1:0] sm;
        logic [DAY_W-1:0]   sd;
        bit                 typed;
        date_answer_t       want;
    } date_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [YEAR_W-1:0]  s_first_year = '0;
    logic [MONTH_W-1:0] s_first_month = '0;
    logic [DAY_W-1:0]   s_first_day = '0;
    logic [YEAR_W-1:0]  s_second_year = '0;
    logic [MONTH_W-1:0] s_second_month = '0;
    logic [DAY_W-1:0]   s_second_day = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [YEAR_W-1:0]  m_next_year;
    logic [MONTH_W-1:0] m_next_month;
    logic [DAY_W-1:0]   m_next_day;
    logic [YEAR_W-1:0]  m_prev_year;
    logic [MONTH_W-1:0] m_prev_month;
    logic [DAY_W-1:0]   m_prev_day;
    logic               m_leap_flag;
    logic [DOY_W-1:0]   m_day_of_year;
    logic [WEEK_W-1:0]  m_week_of_year;
    logic [DIFF_W-1:0]  m_days_between;

    // typed answer travels with the payload so the monitor sees it stable
    bit                 cur_typed = 1'b0;
    date_answer_t       cur_want = '0;
    bit                 steady = 1'b0;

    date_answer_t       dates_due[$];
    date_row_t          date_table[$];
    int                 errors = 0;
    int                 idle_cycles = 0;
    int                 ready_hold = 0;

    calendar_date_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_first_year   (s_first_year),
        .s_first_month  (s_first_month),
        .s_first_day    (s_first_day),
        .s_second_year  (s_second_year),
        .s_second_month (s_second_month),
        .s_second_day   (s_second_day),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_next_year    (m_next_year),
        .m_next_month   (m_next_month),
        .m_next_day     (m_next_day),
        .m_prev_year    (m_prev_year),
        .m_prev_month   (m_prev_month),
        .m_prev_day     (m_prev_day),
        .m_leap_flag    (m_leap_flag),
        .m_day_of_year  (m_day_of_year),
        .m_week_of_year (m_week_of_year),
        .m_days_between (m_days_between)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit leap_year(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int month_days(input int y, input int m);
        int n;
        case (m)
            MONTH_FEB: n = leap_year(y) ? 29 : 28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = 30;
            default: n = 31;
        endcase
        return n;
    endfunction

    function automatic int days_before_month(input int m);
        int s;
        case (m)
            2:  s = 31;
            3:  s = 59;
            4:  s = 90;
            5:  s = 120;
            6:  s = 151;
            7:  s = 181;
            8:  s = 212;
            9:  s = 243;
            10: s = 273;
            11: s = 304;
            12: s = 334;
            default: s = 0;
        endcase
        return s;
    endfunction

    // day number with a 400-year offset; the offset cancels in a difference
    function automatic longint day_number(input int y, input int m, input int d);
        longint t;
        t = longint'(y) + 400 - ((m <= 2) ? 1 : 0);
        return longint'(y) * 365 + days_before_month(m) + d + t / 4 - t / 100 + t / 400;
    endfunction

    function automatic void clamp_date(inout int y, inout int m, inout int d);
        int len;
        if (m < 1) m = 1;
        if (m > 12) m = 12;
        len = month_days(y, m);
        if (d < 1) d = 1;
        if (d > len) d = len;
    endfunction

    function automatic date_answer_t calendar_calc(
        input logic [YEAR_W-1:0] fy, input logic [MONTH_W-1:0] fm,
        input logic [DAY_W-1:0] fd, input logic [YEAR_W-1:0] sy,
        input logic [MONTH_W-1:0] sm, input logic [DAY_W-1:0] sd);
        date_answer_t r;
        int y, m, d, y2, m2, d2, doy;
        bit leap;
        longint span;
        y = fy;
        m = fm;
        d = fd;
        y2 = sy;
        m2 = sm;
        d2 = sd;
        clamp_date(y, m, d);
        clamp_date(y2, m2, d2);
        leap = leap_year(y);
        if (d == month_days(y, m)) begin
            r.next_year  = YEAR_W'((m == MONTH_DEC) ? y + 1 : y);
            r.next_month = MONTH_W'((m == MONTH_DEC) ? 1 : m + 1);
            r.next_day   = DAY_W'(1);
        end else begin
            r.next_year  = YEAR_W'(y);
            r.next_month = MONTH_W'(m);
            r.next_day   = DAY_W'(d + 1);
        end
        if (d == 1 && m == MONTH_JAN) begin
            r.prev_year  = YEAR_W'(y - 1);
            r.prev_month = MONTH_DEC;
            r.prev_day   = DAY_W'(31);
        end else if (d == 1) begin
            r.prev_year  = YEAR_W'(y);
            r.prev_month = MONTH_W'(m - 1);
            r.prev_day   = DAY_W'(month_days(y, m - 1));
        end else begin
            r.prev_year  = YEAR_W'(y);
            r.prev_month = MONTH_W'(m);
            r.prev_day   = DAY_W'(d - 1);
        end
        doy = days_before_month(m) + d + ((m > 2 && leap) ? 1 : 0);
        r.leap_flag    = leap;
        r.day_of_year  = DOY_W'(doy);
        r.week_of_year = WEEK_W'((doy + 6) / 7);
        span = day_number(y, m, d) - day_number(y2, m2, d2);
        if (span < 0) span = -span;
        if (span > longint'(DIFF_MAX)) span = longint'(DIFF_MAX);
        r.days_between = DIFF_W'(span);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic pick_date(output logic [YEAR_W-1:0] y, output logic [MONTH_W-1:0] m,
                             output logic [DAY_W-1:0] d);
        int r, len;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            // raw bits: months and days out of range, years past 9999
            y = YEAR_W'($urandom);
            m = MONTH_W'($urandom);
            d = DAY_W'($urandom);
        end else begin
            if (r < 20) y = YEAR_W'($urandom_range(1, 99) * 100);
            else if (r < 25) y = YEAR_W'($urandom_range(1, 12));
            else if (r < 30) y = YEAR_W'($urandom_range(9988, 9999));
            else y = YEAR_W'($urandom_range(1, 9999));
            m = MONTH_W'($urandom_range(1, 12));
            len = month_days(y, m);
            case ($urandom_range(0, 9))
                0: d = DAY_W'(1);
                1: d = DAY_W'(len);
                2: d = DAY_W'(len - 1);
                3: begin
                    m = MONTH_FEB;
                    d = DAY_W'($urandom_range(28, 29));
                    if (!leap_year(y)) d = DAY_W'(28);
                end
                default: d = DAY_W'($urandom_range(1, len));
            endcase
        end
    endtask

    task automatic add_row(input int fy, input int fm, input int fd,
                           input int sy, input int sm, input int sd);
        date_row_t row;
        row.fy = YEAR_W'(fy);
        row.fm = MONTH_W'(fm);
        row.fd = DAY_W'(fd);
        row.sy = YEAR_W'(sy);
        row.sm = MONTH_W'(sm);
        row.sd = DAY_W'(sd);
        row.typed = 1'b0;
        row.want = '0;
        date_table.push_back(row);
    endtask

    task automatic add_typed(input int fy, input int fm, input int fd,
                             input int sy, input int sm, input int sd,
                             input int ny, input int nm, input int nd,
                             input int py, input int pm, input int pd,
                             input int lf, input int doy, input int wk, input int span);
        date_row_t row;
        row.fy = YEAR_W'(fy);
        row.fm = MONTH_W'(fm);
        row.fd = DAY_W'(fd);
        row.sy = YEAR_W'(sy);
        row.sm = MONTH_W'(sm);
        row.sd = DAY_W'(sd);
        row.typed = 1'b1;
        row.want = '{YEAR_W'(ny), MONTH_W'(nm), DAY_W'(nd), YEAR_W'(py), MONTH_W'(pm),
                     DAY_W'(pd), 1'(lf), DOY_W'(doy), WEEK_W'(wk), DIFF_W'(span)};
        date_table.push_back(row);
    endtask

    task automatic send_dates(input date_row_t row);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_first_year   <= row.fy;
        s_first_month  <= row.fm;
        s_first_day    <= row.fd;
        s_second_year  <= row.sy;
        s_second_month <= row.sm;
        s_second_day   <= row.sd;
        cur_typed      <= row.typed;
        cur_want       <= row.want;
        s_valid        <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        do @(negedge aclk); while (dates_due.size() != 0);
        @(posedge aclk);
    endtask

    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            ready_hold = pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        date_answer_t w;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (dates_due.size() == 0) begin
                    flag_mismatch("result transfer with nothing expected");
                end else begin
                    w = dates_due.pop_front();
                    if (m_next_year !== w.next_year)
                        flag_mismatch($sformatf("next_year %0d, want %0d", m_next_year, w.next_year));
                    if (m_next_month !== w.next_month)
                        flag_mismatch($sformatf("next_month %0d, want %0d", m_next_month, w.next_month));
                    if (m_next_day !== w.next_day)
                        flag_mismatch($sformatf("next_day %0d, want %0d", m_next_day, w.next_day));
                    if (m_prev_year !== w.prev_year)
                        flag_mismatch($sformatf("prev_year %0d, want %0d", m_prev_year, w.prev_year));
                    if (m_prev_month !== w.prev_month)
                        flag_mismatch($sformatf("prev_month %0d, want %0d", m_prev_month, w.prev_month));
                    if (m_prev_day !== w.prev_day)
                        flag_mismatch($sformatf("prev_day %0d, want %0d", m_prev_day, w.prev_day));
                    if (m_leap_flag !== w.leap_flag)
                        flag_mismatch($sformatf("leap_flag %0d, want %0d", m_leap_flag, w.leap_flag));
                    if (m_day_of_year !== w.day_of_year)
                        flag_mismatch($sformatf("day_of_year %0d, want %0d",
                                                m_day_of_year, w.day_of_year));
                    if (m_week_of_year !== w.week_of_year)
                        flag_mismatch($sformatf("week_of_year %0d, want %0d",
                                                m_week_of_year, w.week_of_year));
                    if (m_days_between !== w.days_between)
                        flag_mismatch($sformatf("days_between %0d, want %0d",
                                                m_days_between, w.days_between));
                end
            end
            if (s_valid && s_ready) begin
                if (cur_typed)
                    dates_due.push_back(cur_want);
                else
                    dates_due.push_back(calendar_calc(s_first_year, s_first_month, s_first_day,
                                                      s_second_year, s_second_month,
                                                      s_second_day));
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        date_row_t row;
        int n;
        // year limits, wrap of both neighbors, leap days, clamping, saturation
        add_typed(1, 1, 1, 1, 1, 1, 1, 1, 2, 0, 12, 31, 0, 1, 1, 0);
        add_typed(16383, 12, 31, 16383, 12, 31, 0, 1, 1, 16383, 12, 30, 0, 365, 53, 0);
        add_typed(0, 1, 1, 0, 1, 1, 0, 1, 2, 16383, 12, 31, 1, 1, 1, 0);
        add_typed(0, 1, 1, 16383, 12, 31, 0, 1, 2, 16383, 12, 31, 1, 1, 1, 4194303);
        add_typed(2000, 2, 28, 2000, 2, 28, 2000, 2, 29, 2000, 2, 27, 1, 59, 9, 0);
        add_typed(2024, 3, 1, 2024, 2, 29, 2024, 3, 2, 2024, 2, 29, 1, 61, 9, 1);
        add_typed(2023, 0, 0, 2023, 1, 1, 2023, 1, 2, 2022, 12, 31, 0, 1, 1, 0);
        add_typed(2023, 15, 31, 2023, 12, 31, 2024, 1, 1, 2023, 12, 30, 0, 365, 53, 0);
        add_typed(9999, 12, 31, 1, 1, 1, 10000, 1, 1, 9999, 12, 30, 0, 365, 53, 3652058);
        add_row(1, 1, 1, 9999, 12, 31);
        add_row(1900, 2, 28, 2000, 2, 29);
        add_row(1900, 2, 29, 1900, 3, 1);
        add_row(2000, 2, 29, 2100, 3, 1);
        add_row(2000, 12, 31, 2001, 1, 1);
        add_row(2023, 4, 31, 2023, 5, 1);
        add_row(2023, 3, 1, 2024, 3, 1);
        add_row(2100, 3, 1, 2400, 2, 29);
        add_row(2400, 2, 29, 1600, 2, 29);
        add_row(16383, 2, 29, 0, 2, 29);
        add_row(0, 2, 29, 8191, 8, 16);
        add_row(2024, 7, 15, 1970, 1, 1);
        add_row(8192, 13, 0, 4096, 0, 31);
        add_row(5000, 6, 30, 10000, 9, 31);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (date_table[i]) send_dates(date_table[i]);
        s_valid <= 1'b0;
        drain_results();

        for (n = 0; n < ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                steady <= ((n / PHASE_LEN) % 4 == 2);
                if (n == 5 * PHASE_LEN) begin
                    s_valid <= 1'b0;
                    drain_results();
                end
            end
            pick_date(row.fy, row.fm, row.fd);
            if ($urandom_range(0, 99) < 15) begin
                row.sy = row.fy;
                row.sm = row.fm;
                row.sd = row.fd;
            end else begin
                pick_date(row.sy, row.sm, row.sd);
            end
            row.typed = 1'b0;
            row.want = '0;
            send_dates(row);
        end
        s_valid <= 1'b0;
        drain_results();
        repeat (8) @(posedge aclk);

        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
